[sv/rff_pkg.sv]
// rx_fifo_flow_control shared package: sizes, codes, ring pointer helpers
// and the structs passed between the control unit and the top level.
// No dependencies.
`default_nettype none

package rff_pkg;

    localparam int DEPTH      = 1024;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int BYTE_W     = 8;
    localparam int FILL_W     = 10;
    localparam int HW_W       = 10;
    localparam int CMP_W      = (ADDR_W > HW_W) ? ADDR_W : HW_W;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int IN_DATA_W  = 8;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 24;

    localparam logic [HW_W-1:0]   HW_RESET = 10'd992;
    localparam logic [BYTE_W-1:0] CMD_MARK = 8'h24;    // '$'

    // register index, taken from paddr[2]
    localparam logic REG_HIGH_WATER = 1'b0;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [BYTE_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

    typedef struct packed {
        logic [FILL_W-1:0] fill_count;
        logic              overflow;
        logic              command_ready;
        logic              cts_stop;
        logic              pop_valid;
        logic [BYTE_W-1:0] pop_data;
    } result_t;

    function automatic logic [ADDR_W-1:0] ring_next(input logic [ADDR_W-1:0] p);
        return (p == ADDR_W'(DEPTH - 1)) ? '0 : p + ADDR_W'(1);
    endfunction

    // entries between read pointer and the slot after the last write
    function automatic logic [ADDR_W-1:0] ring_fill(input logic [ADDR_W-1:0] wp,
                                                    input logic [ADDR_W-1:0] rp);
        logic [ADDR_W:0] diff;
        diff = {1'b0, ring_next(wp)} - {1'b0, rp};
        if (diff[ADDR_W])
        begin
            diff = diff + (ADDR_W + 1)'(DEPTH);
        end
        return diff[ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

[sv/rff_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module rff_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[sv/rff_cfg.sv]
// APB register file: the high water mark register.
// Depends on rff_pkg.
`default_nettype none

module rff_cfg
    import rff_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output logic      [HW_W-1:0]       high_water
);

    logic [HW_W-1:0] hw_reg;
    logic [HW_W-1:0] hw_next;
    logic            hit;

    assign pready     = 1'b1;
    assign hit        = (paddr[2] == REG_HIGH_WATER);
    assign high_water = hw_reg;

    always_comb
    begin
        hw_next = hw_reg;
        if (psel && penable && pwrite && pready && hit)
        begin
            hw_next = pwdata[HW_W-1:0];
        end
        prdata = hit ? APB_DATA_W'(hw_reg) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hw_reg <= HW_RESET;
        end
        else
        begin
            hw_reg <= hw_next;
        end
    end

endmodule

`default_nettype wire

[sv/rff_ctrl.sv]
// Queue control: pointers, flags and the two-step sequencer around the store.
// Depends on rff_pkg.
`default_nettype none

module rff_ctrl
    import rff_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic [IN_USER_W-1:0] in_op,
    input  wire logic [BYTE_W-1:0]    in_byte,
    output logic                      in_ready,
    input  wire logic [HW_W-1:0]      high_water,
    output ram_req_t                  ram_req,
    input  wire logic [BYTE_W-1:0]    ram_rdata,
    output logic                      res_valid,
    output result_t                   res,
    input  wire logic                 res_ack
);

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] rp_reg, rp_next;
    logic [ADDR_W-1:0] wp_reg, wp_next;
    logic              stop_reg, stop_next;
    logic              cmd_reg, cmd_next;
    logic              push_reg, push_next;
    logic              valid_reg, valid_next;
    logic              drop_reg, drop_next;

    logic [ADDR_W-1:0] fill_cur;
    logic [ADDR_W-1:0] fill_push;
    logic              full;
    logic              empty;
    logic              cmd_hit;

    always_comb
    begin
        fill_cur  = ring_fill(wp_reg, rp_reg);
        full      = (fill_cur == ADDR_W'(DEPTH - 1));
        empty     = (fill_cur == '0);
        fill_push = full ? fill_cur : fill_cur + ADDR_W'(1);
        // pointers already moved at accept, so fill_cur is the post-item count
        cmd_hit   = push_reg && (ram_rdata == CMD_MARK) && (fill_cur > ADDR_W'(1));

        state_next = state_reg;
        rp_next    = rp_reg;
        wp_next    = wp_reg;
        stop_next  = stop_reg;
        cmd_next   = cmd_reg;
        push_next  = push_reg;
        valid_next = valid_reg;
        drop_next  = drop_reg;
        in_ready   = 1'b0;
        res_valid  = 1'b0;
        ram_req    = '0;

        res.fill_count    = FILL_W'(fill_cur);
        res.overflow      = drop_reg;
        res.command_ready = cmd_reg | cmd_hit;
        res.cts_stop      = stop_reg;
        res.pop_valid     = valid_reg;
        res.pop_data      = valid_reg ? ram_rdata : '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next    = ST_EXEC;
                    ram_req.re    = 1'b1;
                    ram_req.raddr = rp_reg;
                    push_next     = 1'b0;
                    valid_next    = 1'b0;
                    drop_next     = 1'b0;
                    unique case (op_t'(in_op))
                        OP_PUSH:
                        begin
                            push_next = 1'b1;
                            drop_next = full;
                            stop_next = CMP_W'(fill_push) > CMP_W'(high_water);
                            if (!full)
                            begin
                                wp_next       = ring_next(wp_reg);
                                ram_req.we    = 1'b1;
                                ram_req.waddr = ring_next(wp_reg);
                                ram_req.wdata = in_byte;
                            end
                        end
                        OP_POP:
                        begin
                            if (!empty)
                            begin
                                valid_next = 1'b1;
                                rp_next    = ring_next(rp_reg);
                            end
                        end
                        OP_CLEAR:
                        begin
                            rp_next  = '0;
                            wp_next  = ADDR_W'(DEPTH - 1);
                            cmd_next = 1'b0;
                        end
                        OP_NOP:
                        begin
                        end
                    endcase
                end
            end
            ST_EXEC:
            begin
                res_valid = 1'b1;
                if (res_ack)
                begin
                    cmd_next   = cmd_reg | cmd_hit;
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rp_reg    <= '0;
            wp_reg    <= ADDR_W'(DEPTH - 1);
            stop_reg  <= 1'b0;
            cmd_reg   <= 1'b0;
            push_reg  <= 1'b0;
            valid_reg <= 1'b0;
            drop_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rp_reg    <= rp_next;
            wp_reg    <= wp_next;
            stop_reg  <= stop_next;
            cmd_reg   <= cmd_next;
            push_reg  <= push_next;
            valid_reg <= valid_next;
            drop_reg  <= drop_next;
        end
    end

endmodule

`default_nettype wire

[sv/rx_fifo_flow_control.sv]
// Receive byte queue with high water flow control and '$' command detection.
// Depends on rff_pkg, rff_ram, rff_cfg, rff_ctrl.
//
// Each input item carries an operation (push, pop, clear, no-op) and a byte,
// and produces exactly one result item with the popped byte, the stop flag
// for the sender, the sticky command flag, the overflow flag and the fill
// count. The queue holds at most DEPTH-1 bytes in a single-port-write,
// single-port-read RAM with a registered read. An item passes two states:
// the accept state updates the pointers, the stop flag and issues the head
// read (plus the write for a push); the execute state, in the next cycle,
// uses the read data to form the popped byte and the command check and
// loads the output register once it is free. No new item is taken until
// then; the output register lets the next item in while a result waits.
// The byte store needs no clearing pass after reset; the block is ready as
// soon as rst_n is released. high_water sits at APB byte address 0 and must
// only be written while no item is in flight.
`default_nettype none

module rx_fifo_flow_control
    import rff_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // input stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic [IN_USER_W-1:0]  s_tuser,   // [1:0] op
    // result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [7:0] pop_data, [8] pop_valid, [9] cts_stop, [10] command_ready,
    // [11] overflow, [21:12] fill_count, [23:22] zero
    output logic      [OUT_DATA_W-1:0] m_tdata,
    // configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    logic [HW_W-1:0]   high_water;
    ram_req_t          ram_req;
    logic [BYTE_W-1:0] ram_rdata;
    logic              res_valid;
    result_t           res;
    logic              res_ack;

    logic              out_valid_reg, out_valid_next;
    result_t           out_data_reg;

    rff_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .high_water (high_water)
    );

    rff_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_op      (s_tuser),
        .in_byte    (s_tdata[BYTE_W-1:0]),
        .in_ready   (s_tready),
        .high_water (high_water),
        .ram_req    (ram_req),
        .ram_rdata  (ram_rdata),
        .res_valid  (res_valid),
        .res        (res),
        .res_ack    (res_ack)
    );

    // byte store
    rff_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    // output register: load when empty or being drained this cycle
    assign res_ack = res_valid && (!out_valid_reg || m_tready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_ack)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ack)
        begin
            out_data_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'(out_data_reg);

endmodule

`default_nettype wire
